### rtl/mrc_pkg.sv
// Package for the Modbus RTU response checker: shared constants, status codes,
// the queue item type and the byte-wide CRC-16/MODBUS update function.
// Depends on nothing; every other file but mrc_if uses it.
package mrc_pkg;

   // Frame position and length counters.
   localparam int POS_W             = 9;
   localparam int MAX_FRAME_DEFAULT = 256;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Protocol constants.
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;
   localparam logic [7:0]  EXC_LIMIT        = 8'h80;
   localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h01;
   localparam logic [POS_W-1:0] HEADER_LEN  = POS_W'(3);
   localparam logic [POS_W:0]   LEN_MARGIN  = (POS_W + 1)'(5);

   // Frame status codes, in priority order.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_CRC_SHORT = 3'd1;
   localparam logic [2:0] STATUS_BAD_SLAVE = 3'd2;
   localparam logic [2:0] STATUS_BAD_LEN   = 3'd3;
   localparam logic [2:0] STATUS_EXCEPTION = 3'd4;

   // One classified byte as it travels from the front to the back.
   typedef struct packed {
      logic [7:0]       rx_byte;
      logic             frame_end;
      logic [POS_W-1:0] pos;        // position of this byte in its frame
      logic [POS_W-1:0] len;        // frame length after counting this byte
      logic             addr_match; // byte equals the slave address
   } item_type;

   // Folds one byte into the reflected CRC-16/MODBUS accumulator.
   function automatic logic [15:0] crc_byte(input logic [15:0] acc,
                                            input logic [7:0]  b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/mrc_if.sv
// Channel interfaces of the Modbus RTU response checker: received bytes,
// result beats and the slave address write port. No dependencies.
interface mrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] echo_byte;
   logic       is_payload;
   logic       frame_done;
   logic [2:0] status;
   logic [7:0] function_code;
   logic [7:0] byte_count;

   modport source (output valid, output echo_byte, output is_payload,
                   output frame_done, output status, output function_code,
                   output byte_count, input ready);
   modport sink   (input valid, input echo_byte, input is_payload,
                   input frame_done, input status, input function_code,
                   input byte_count, output ready);
endinterface

interface mrc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] wdata;

   modport source (output valid, output wdata, input ready);
   modport sink   (input valid, input wdata, output ready);
endinterface

### rtl/mrc_front.sv
// Front of the checker: accepts bytes, counts positions within the frame,
// compares against the slave address register and pushes classified items.
// Depends on mrc_pkg and mrc_if.
module mrc_front #(
   parameter int MAX_FRAME = mrc_pkg::MAX_FRAME_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   mrc_req_if.sink           req_ch,
   mrc_csr_if.sink           csr_ch,
   input  logic              q_full,
   output logic              push,
   output mrc_pkg::item_type push_item
);
   import mrc_pkg::*;

   localparam logic [POS_W-1:0] MaxCount = POS_W'(MAX_FRAME);

   logic [7:0]       slave_addr_ff;
   logic [POS_W-1:0] bytes_seen_ff;
   logic [POS_W-1:0] bytes_seen_in;
   logic [POS_W-1:0] len;

   // The register port never stalls.
   assign csr_ch.ready = 1'b1;

   // A byte is taken whenever the queue has room.
   assign req_ch.ready = !q_full;
   assign push         = req_ch.valid && !q_full;

   // Frame length after this byte, saturating at the longest frame.
   assign len = (bytes_seen_ff < MaxCount) ? bytes_seen_ff + POS_W'(1) : bytes_seen_ff;

   // The count rearms after the final byte of a frame.
   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      if (push) begin
         bytes_seen_in = req_ch.frame_end ? '0 : len;
      end
   end

   always_comb begin
      push_item.rx_byte    = req_ch.rx_byte;
      push_item.frame_end  = req_ch.frame_end;
      push_item.pos        = bytes_seen_ff;
      push_item.len        = len;
      push_item.addr_match = (req_ch.rx_byte == slave_addr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= SLAVE_ADDR_RESET;
         bytes_seen_ff <= '0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         if (csr_ch.valid) begin
            slave_addr_ff <= csr_ch.wdata;
         end
      end
   end

endmodule

### rtl/mrc_queue.sv
// Short queue between the front and the back of the checker.
// Depends on mrc_pkg for the item type and the depth.
module mrc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mrc_pkg::item_type push_item,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output mrc_pkg::item_type head_item
);
   import mrc_pkg::*;

   localparam logic [QPTR_W-1:0] LastPtr = QPTR_W'(QUEUE_DEPTH - 1);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops; both may happen in one cycle.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/mrc_back.sv
// Back of the checker: runs the CRC, holds the header fields, flags payload
// bytes and computes the frame status into the result register.
// Depends on mrc_pkg and mrc_if.
module mrc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  mrc_pkg::item_type q_item,
   output logic              q_pop,
   mrc_rsp_if.source         rsp_ch
);
   import mrc_pkg::*;

   logic [15:0] crc_ff;
   logic        addr_ok_ff;
   logic [7:0]  held_func_ff;
   logic [7:0]  held_count_ff;
   logic        rsp_valid_ff;

   logic [7:0]  echo_ff;
   logic        payload_ff;
   logic        done_ff;
   logic [2:0]  status_ff;
   logic [7:0]  func_out_ff;
   logic [7:0]  count_out_ff;

   logic [15:0] crc_in;
   logic        addr_ok_in;
   logic [7:0]  held_func_in;
   logic [7:0]  held_count_in;
   logic        payload_in;
   logic [2:0]  status_in;
   logic [7:0]  count_out_in;
   logic        is_first;

   // Take the next beat when the result register is free or being drained.
   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_ch.ready);

   assign crc_in   = crc_byte(crc_ff, q_item.rx_byte);
   assign is_first = (q_item.pos == '0);

   // Header capture and payload flag by position in the frame.
   always_comb begin
      addr_ok_in    = addr_ok_ff;
      held_func_in  = held_func_ff;
      held_count_in = held_count_ff;
      payload_in    = 1'b0;
      if (is_first) begin
         addr_ok_in    = q_item.addr_match;
         held_func_in  = '0;
         held_count_in = '0;
      end else if (q_item.pos == POS_W'(1)) begin
         held_func_in = q_item.rx_byte;
      end else if (q_item.pos == POS_W'(2)) begin
         held_count_in = q_item.rx_byte;
      end else begin
         payload_in = ((q_item.pos - HEADER_LEN) < {1'b0, held_count_ff});
      end
   end

   // Status in priority order; the length check is count + 5 > length.
   always_comb begin
      status_in    = STATUS_OK;
      count_out_in = held_count_in;
      if (q_item.frame_end) begin
         if ((q_item.len < POS_W'(3)) || (crc_in != 16'h0000)) begin
            status_in = STATUS_CRC_SHORT;
         end else if (!addr_ok_in) begin
            status_in = STATUS_BAD_SLAVE;
         end else if (({2'b00, held_count_in} + LEN_MARGIN) > {1'b0, q_item.len}) begin
            status_in    = STATUS_BAD_LEN;
            count_out_in = '0;
         end else if (held_func_in > EXC_LIMIT) begin
            status_in = STATUS_EXCEPTION;
         end
      end
   end

   // Control state and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= CRC_INIT;
         addr_ok_ff    <= 1'b0;
         held_func_ff  <= '0;
         held_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            held_func_ff  <= held_func_in;
            held_count_ff <= held_count_in;
            if (q_item.frame_end) begin
               crc_ff     <= CRC_INIT;
               addr_ok_ff <= 1'b0;
            end else begin
               crc_ff     <= crc_in;
               addr_ok_ff <= addr_ok_in;
            end
         end
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         echo_ff      <= q_item.rx_byte;
         payload_ff   <= payload_in;
         done_ff      <= q_item.frame_end;
         status_ff    <= status_in;
         func_out_ff  <= held_func_in;
         count_out_ff <= count_out_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.echo_byte     = echo_ff;
   assign rsp_ch.is_payload    = payload_ff;
   assign rsp_ch.frame_done    = done_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.function_code = func_out_ff;
   assign rsp_ch.byte_count    = count_out_ff;

endmodule

### rtl/modbus_rtu_response_checker_core.sv
// Top level of the Modbus RTU response checker: front, queue and back.
// Depends on mrc_pkg, mrc_if, mrc_front, mrc_queue and mrc_back.
//
//   channel  direction  beat contents
//   req_ch   in         rx_byte, frame_end
//   rsp_ch   out        echo_byte, is_payload, frame_done, status,
//                       function_code, byte_count
//   csr_ch   in         wdata (slave address)
//
// One byte per cycle sustained while results are taken. An accepted byte
// is written into the queue, then popped into the result register that offers it.
// The back unrolls the eight-bit CRC step, one byte a cycle unless stalled.
// Reset is synchronous and returns the slave address to 1 and rearms the frame.
// A stalled result holds; the two-entry queue takes two more beats, then the
// input stalls until the result is taken.
module modbus_rtu_response_checker_core #(
   parameter int MAX_FRAME = mrc_pkg::MAX_FRAME_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   mrc_req_if.sink   req_ch,
   mrc_rsp_if.source rsp_ch,
   mrc_csr_if.sink   csr_ch
);
   import mrc_pkg::*;

   logic     push;
   logic     pop;
   logic     q_full;
   logic     q_not_empty;
   item_type push_item;
   item_type head_item;

   // Byte intake and classification.
   mrc_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   // Decoupling queue.
   mrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   // CRC, header tracking and status.
   mrc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_item      (head_item),
      .q_pop       (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

### rtl/mrc_checker.sv
// Port-level checks for the Modbus RTU response checker, bound to the top.
// Depends on mrc_pkg for the status codes.
module mrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       frame_done,
   input logic [2:0] status,
   input logic [7:0] byte_count
);
   import mrc_pkg::*;

   // No result beat directly after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays offered.
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Only the final byte of a frame carries a status.
   a_status_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !frame_done |-> status == STATUS_OK)
      else $error("status reported before frame end");

   // A bad-length frame reports a zero byte count.
   a_bad_len_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done && status == STATUS_BAD_LEN |-> byte_count == 8'h00)
      else $error("byte count kept on bad length");

endmodule

bind modbus_rtu_response_checker_core mrc_checker u_mrc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .frame_done (rsp_ch.frame_done),
   .status     (rsp_ch.status),
   .byte_count (rsp_ch.byte_count)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for modbus_rtu_response_checker_core: drives byte frames, predicts each result beat.
// Depends on mrc_pkg and the channel interfaces in mrc_if.
typedef logic [7:0] byte_list_type[$];

// One result beat as the block reports it.
typedef struct packed {
   logic [7:0] echo_byte;
   logic       is_payload;
   logic       frame_done;
   logic [2:0] status;
   logic [7:0] function_code;
   logic [7:0] byte_count;
} rtu_beat_type;

localparam logic [15:0] CRC_START = 16'hFFFF;
localparam logic [15:0] CRC_TAPS  = 16'hA001;
localparam int          TB_MAX_FRAME = 256;

// Reflected CRC-16 update over one byte, least significant bit first.
function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
   logic [15:0] r;
   r = acc ^ {8'h00, b};
   repeat (8) begin
      r = r[0] ? ({1'b0, r[15:1]} ^ CRC_TAPS) : {1'b0, r[15:1]};
   end
   return r;
endfunction

// Tracks the frame state of the block and holds the beats it still owes.
class rtu_frame_tracker;
   logic [7:0]   slave_addr;
   logic [15:0]  crc_acc;
   logic [8:0]   seen;
   logic         addr_ok;
   logic [7:0]   held_fn;
   logic [7:0]   held_cnt;
   rtu_beat_type due_beats[$];
   int           errors;

   function new();
      slave_addr = 8'h01;
      crc_acc    = CRC_START;
      seen       = '0;
      addr_ok    = 1'b0;
      held_fn    = '0;
      held_cnt   = '0;
      errors     = 0;
   endfunction

   function void set_slave(input logic [7:0] a);
      slave_addr = a;
   endfunction

   function int pending();
      return due_beats.size();
   endfunction

   // Works out the beat caused by one accepted byte.
   function void take_byte(input logic [7:0] b, input logic last);
      rtu_beat_type exp;
      logic [8:0]   p;
      logic [8:0]   len;
      p = seen;
      exp = '0;
      exp.echo_byte  = b;
      exp.frame_done = last;
      crc_acc = crc16_fold(crc_acc, b);

      // The header bytes are captured; later bytes are payload up to the count.
      if (p == 0) begin
         addr_ok  = (b == slave_addr);
         held_fn  = '0;
         held_cnt = '0;
      end else if (p == 1) begin
         held_fn = b;
      end else if (p == 2) begin
         held_cnt = b;
      end else if ((int'(p) - 3) < int'(held_cnt)) begin
         exp.is_payload = 1'b1;
      end

      if (int'(seen) < TB_MAX_FRAME) begin
         seen = seen + 9'd1;
      end
      len = seen;
      exp.function_code = held_fn;
      exp.byte_count    = held_cnt;
      exp.status        = mrc_pkg::STATUS_OK;

      // Frame verdict in priority order, then the frame rearms.
      if (last) begin
         if (len < 9'd3 || crc_acc != 16'h0000) begin
            exp.status = mrc_pkg::STATUS_CRC_SHORT;
         end else if (!addr_ok) begin
            exp.status = mrc_pkg::STATUS_BAD_SLAVE;
         end else if (int'(held_cnt) > int'(len) - 5) begin
            exp.status = mrc_pkg::STATUS_BAD_LEN;
         end else if (held_fn > mrc_pkg::EXC_LIMIT) begin
            exp.status = mrc_pkg::STATUS_EXCEPTION;
         end
         if (exp.status == mrc_pkg::STATUS_BAD_LEN) begin
            exp.byte_count = '0;
         end
         crc_acc = CRC_START;
         seen    = '0;
         addr_ok = 1'b0;
      end
      due_beats.push_back(exp);
   endfunction

   function void report_field(input string name, input int exp, input int got);
      if (exp != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
         errors++;
      end
   endfunction

   // Compares one result beat with the oldest one owed.
   function void check_beat(input rtu_beat_type got);
      rtu_beat_type exp;
      if (due_beats.size() == 0) begin
         $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      exp = due_beats.pop_front();
      report_field("echo_byte", exp.echo_byte, got.echo_byte);
      report_field("is_payload", exp.is_payload, got.is_payload);
      report_field("frame_done", exp.frame_done, got.frame_done);
      report_field("status", exp.status, got.status);
      report_field("function_code", exp.function_code, got.function_code);
      report_field("byte_count", exp.byte_count, got.byte_count);
   endfunction
endclass

module testbench;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 60;

   logic clock;
   logic reset;

   mrc_req_if req_ch();
   mrc_rsp_if rsp_ch();
   mrc_csr_if csr_ch();

   rtu_frame_tracker board = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_req       = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int items_sent     = 0;
   int cycle_count    = 0;
   logic [7:0] cur_slave = 8'h01;

   modbus_rtu_response_checker_core #(.MAX_FRAME(TB_MAX_FRAME)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Free-running clock, 10 ns period.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** modbus_rtu_response_checker_core: FAILED **");
         $finish;
      end
   end

   // Result receiver: random stalls, plus a long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin : result_monitor
      rtu_beat_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.echo_byte     = rsp_ch.echo_byte;
         got.is_payload    = rsp_ch.is_payload;
         got.frame_done    = rsp_ch.frame_done;
         got.status        = rsp_ch.status;
         got.function_code = rsp_ch.function_code;
         got.byte_count    = rsp_ch.byte_count;
         board.check_beat(got);
      end
   end

   // Offers one byte beat after random idle cycles; returns at the next falling edge.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.rx_byte   <= b;
      req_ch.frame_end <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.take_byte(b, last);
      items_sent++;
      @(negedge clock);
   endtask

   // Appends the CRC, low byte first, optionally spoils one bit, and sends the frame.
   task automatic send_with_crc(input byte_list_type body, input bit spoil);
      logic [15:0] crc;
      int k;
      crc = CRC_START;
      foreach (body[i]) crc = crc16_fold(crc, body[i]);
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
      if (spoil) begin
         k = $urandom_range(body.size() - 1);
         body[k] = body[k] ^ 8'(1 << $urandom_range(7));
      end
      for (k = 0; k < body.size(); k++) begin
         send_byte(body[k], k == body.size() - 1);
      end
   endtask

   function automatic byte_list_type make_body(input logic [7:0] addr, input logic [7:0] fn,
                                               input logic [7:0] cnt, input int n_pay);
      byte_list_type q;
      q = {};
      q.push_back(addr);
      q.push_back(fn);
      q.push_back(cnt);
      repeat (n_pay) q.push_back(8'($urandom_range(255)));
      return q;
   endfunction

   // Stops offering until every owed beat has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes the slave address; the block is idle whenever this is called.
   task automatic csr_write(input logic [7:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.wdata <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      board.set_slave(v);
      cur_slave = v;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // One random frame: mostly well formed, the rest broken or noise.
   task automatic send_random_frame();
      int kind;
      int n;
      int len;
      logic [7:0] fn;
      logic [7:0] cnt;
      kind = $urandom_range(99);
      n    = $urandom_range(0, 8);
      fn   = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 16));
      cnt  = ($urandom_range(3) == 0) ? 8'($urandom_range(0, n)) : 8'(n);
      if (kind < 60) begin
         send_with_crc(make_body(cur_slave, fn, cnt, n), 1'b0);
      end else if (kind < 70) begin
         send_with_crc(make_body(cur_slave, fn, 8'(n + $urandom_range(1, 4)), n), 1'b0);
      end else if (kind < 80) begin
         send_with_crc(make_body(cur_slave ^ 8'($urandom_range(1, 255)), fn, cnt, n), 1'b0);
      end else if (kind < 90) begin
         send_with_crc(make_body(cur_slave, fn, cnt, n), 1'b1);
      end else begin
         len = $urandom_range(1, 4);
         for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(255)), (k == len - 1) ? 1'b1 : 1'($urandom_range(1)));
         end
      end
   endtask

   // Main sequence.
   initial begin
      logic [7:0] slave_plan[4];
      int idle_plan[4];
      int stall_plan[4];
      int start;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.rx_byte   = 8'h00;
      req_ch.frame_end = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.wdata     = 8'h00;

      slave_plan = '{8'hFF, 8'h00, 8'($urandom_range(2, 254)), 8'h01};
      idle_plan  = '{0, 72, 0, 37};
      stall_plan = '{0, 0, 72, 37};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames at the reset address: short frames, a minimal good
      // frame, function codes above the exception limit and a wrong slave.
      send_byte(8'h01, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h03, 1'b1);
      send_with_crc(make_body(8'h01, 8'h00, 8'h00, 0), 1'b0);
      send_with_crc(make_body(8'h01, 8'hFF, 8'h00, 0), 1'b0);
      send_with_crc(make_body(8'h01, 8'h81, 8'h01, 1), 1'b0);
      send_with_crc({8'hFF, 8'h80}, 1'b0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_plan[ph];
         recv_stall_pct = stall_plan[ph];
         csr_write(slave_plan[ph]);
         start = items_sent;

         // Long receiver hold-off while the sender keeps offering.
         if (ph == 0 || ph == 3) begin
            hold_req++;
            send_with_crc(make_body(cur_slave, 8'h03, 8'd10, 10), 1'b0);
         end

         // Over-long frame: the length counter saturates.
         if (ph == 2) begin
            send_with_crc(make_body(cur_slave, 8'h04, 8'd255, 258), 1'b0);
         end

         while (items_sent - start < PHASE_ITEMS) begin
            send_random_frame();
            if ($urandom_range(19) == 0) drain();
         end
         drain();
      end

      if (board.errors == 0 && board.pending() == 0) begin
         $display("** modbus_rtu_response_checker_core: PASSED **");
      end else begin
         $display("** modbus_rtu_response_checker_core: FAILED **");
      end
      $finish;
   end
endmodule
